[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the reachability core.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off during reset.
`define GRDFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds.
`define GRDFS_NEVER(lbl, cond, msg) `GRDFS_ASSERT(lbl, !(cond), msg)

`endif

[rtl/grdfs_pkg.sv]
// Shared types and constants of the graph reachability core.
// Used by the controller, the datapath and the top level.
`default_nettype none

package grdfs_pkg;

  localparam int unsigned VertexW        = 5;
  localparam int unsigned CountW         = 6;
  localparam int unsigned OpcodeW        = 2;
  localparam int unsigned MaxVerticesDef = 32;
  localparam int unsigned InDataW        = 16;
  localparam int unsigned OutDataW       = 8;

  localparam logic [CountW-1:0] CountReset = 6'd32;

  typedef enum logic [OpcodeW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_POP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic start;
    logic emit_bad;
    logic push;
    logic pop_req;
    logic pop_load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_query;
    logic start_bad;
    logic slot_free;
    logic found;
    logic stack_empty;
  } status_t;

endpackage

`default_nettype wire

[rtl/grdfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module grdfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/grdfs_ctrl.sv]
// Controller state machine of the reachability core.
// Depends on grdfs_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none

module grdfs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  grdfs_pkg::status_t sts_i,
  output grdfs_pkg::cmd_t    cmd_o
);
  import grdfs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.in_query) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (!sts_i.start_bad) begin
          state_d = ST_SCAN;
        end else if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!sts_i.found) begin
          state_d = sts_i.stack_empty ? ST_FINISH : ST_POP;
        end
      end
      ST_POP: begin
        state_d = ST_SCAN;
      end
      ST_FINISH: begin
        if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_START: begin
        if (sts_i.start_bad) begin
          cmd_o.emit_bad = sts_i.slot_free;
        end else begin
          cmd_o.start = 1'b1;
        end
      end
      ST_SCAN: begin
        if (sts_i.found) begin
          cmd_o.push = sts_i.slot_free;
        end else if (!sts_i.stack_empty) begin
          cmd_o.pop_req = 1'b1;
        end
      end
      ST_POP: begin
        cmd_o.pop_load = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = sts_i.slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/grdfs_dpath.sv]
// Datapath of the reachability core: adjacency matrix, visited mask, walk stack,
// neighbor scan and output register. Depends on grdfs_pkg and grdfs_ram.
`default_nettype none

module grdfs_dpath #(
  parameter int unsigned MAX_VERTICES = grdfs_pkg::MaxVerticesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [grdfs_pkg::CountW-1:0]     cfg_data_i,
  input  logic [grdfs_pkg::InDataW-1:0]    in_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [grdfs_pkg::OutDataW-1:0]   out_data_o,
  output logic                             out_last_o,
  output logic                             out_bad_o,
  input  grdfs_pkg::cmd_t                  cmd_i,
  output grdfs_pkg::status_t               sts_o
);
  import grdfs_pkg::*;

  localparam int unsigned NumRows = (MAX_VERTICES < (2 ** VertexW)) ? MAX_VERTICES
                                                                    : (2 ** VertexW);
  localparam int unsigned RowIdxW = $clog2(NumRows);
  localparam int unsigned UseW    = CountW + 1;
  localparam logic [UseW-1:0] MaxCount = UseW'(MAX_VERTICES);

  logic [CountW-1:0]  count_q;
  logic [UseW-1:0]    n_use;
  opcode_e            in_op;
  logic [VertexW-1:0] in_a, in_b;
  logic [RowIdxW-1:0] ia, ib;
  logic               edit_en, edit_set;

  logic [NumRows-1:0] adj_q [NumRows];
  logic [NumRows-1:0] visited_q;
  logic [NumRows-1:0] lim_mask, cand;
  logic [VertexW-1:0] a_q;
  logic [RowIdxW-1:0] cur_q, pend_q, sp_q, found_idx, stack_rdata;
  logic               found, slot_free, emit;

  logic               out_valid_q, out_last_q, out_bad_q;
  logic [VertexW-1:0] out_vertex_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign n_use = ({1'b0, count_q} > MaxCount) ? MaxCount : {1'b0, count_q};

  assign in_op    = opcode_e'(in_data_i[OpcodeW-1:0]);
  assign in_a     = in_data_i[OpcodeW +: VertexW];
  assign in_b     = in_data_i[OpcodeW+VertexW +: VertexW];
  assign ia       = in_a[RowIdxW-1:0];
  assign ib       = in_b[RowIdxW-1:0];
  assign edit_set = (in_op == OP_ADD);
  assign edit_en  = cmd_i.accept && ((in_op == OP_ADD) || (in_op == OP_REMOVE)) &&
                    (UseW'(in_a) < n_use) && (UseW'(in_b) < n_use);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) begin
        adj_q[r] <= '0;
      end
    end else if (edit_en) begin
      adj_q[ia][ib] <= edit_set;
      if (ia != ib) begin
        adj_q[ib][ia] <= edit_set;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NumRows; j++) begin
      lim_mask[j] = (UseW'(j) < n_use);
    end
  end

  assign cand = adj_q[cur_q] & ~visited_q & lim_mask;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int j = NumRows - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found     = 1'b1;
        found_idx = RowIdxW'(j);
      end
    end
  end

  grdfs_ram #(
    .Width (RowIdxW),
    .Depth (NumRows)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (sp_q),
    .wdata_i (cur_q),
    .re_i    (cmd_i.pop_req),
    .raddr_i (RowIdxW'(sp_q - 1'b1)),
    .rdata_o (stack_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      a_q <= in_a;
    end
    if (cmd_i.start) begin
      visited_q <= NumRows'(1) << a_q[RowIdxW-1:0];
      cur_q     <= a_q[RowIdxW-1:0];
      pend_q    <= a_q[RowIdxW-1:0];
    end else if (cmd_i.push) begin
      visited_q[found_idx] <= 1'b1;
      cur_q                <= found_idx;
      pend_q               <= found_idx;
    end else if (cmd_i.pop_load) begin
      cur_q <= stack_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else if (cmd_i.start) begin
      sp_q <= '0;
    end else if (cmd_i.push) begin
      sp_q <= RowIdxW'(sp_q + 1'b1);
    end else if (cmd_i.pop_req) begin
      sp_q <= RowIdxW'(sp_q - 1'b1);
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = cmd_i.push || cmd_i.finish || cmd_i.emit_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_vertex_q <= cmd_i.emit_bad ? '0 : VertexW'(pend_q);
      out_last_q   <= cmd_i.finish || cmd_i.emit_bad;
      out_bad_q    <= cmd_i.emit_bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {(OutDataW - VertexW)'(0), out_vertex_q};
  assign out_last_o  = out_last_q;
  assign out_bad_o   = out_bad_q;

  assign sts_o.in_query    = (in_op == OP_QUERY);
  assign sts_o.start_bad   = !(UseW'(a_q) < n_use);
  assign sts_o.slot_free   = slot_free;
  assign sts_o.found       = found;
  assign sts_o.stack_empty = (sp_q == '0);

endmodule

`default_nettype wire

[rtl/graph_reachability_dfs_core.sv]
// Top level of the graph reachability core: controller, datapath, assertions.
// Depends on grdfs_pkg, grdfs_ctrl, grdfs_dpath and assert_macros.svh.
//
//   channel   | direction | handshake                    | payload
//   ----------+-----------+------------------------------+--------------------------------
//   s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: opcode, node_a, node_b
//   m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: vertex; tlast; tuser: bad
//   cfg       | in        | cfg_valid_i/cfg_ready_o      | cfg_data_i: vertex_count
//
// Edge add or remove is written into the adjacency matrix in the accept cycle itself.
// A query steps through START, then SCAN for each push, SCAN and POP for each pop
// (POP waits on the registered read port of the stack RAM), and FINISH; a bad start
// vertex is reported from START, which then returns to IDLE.
// Reset clears the adjacency matrix at once; no clearing pass.
// A full output register stalls the walk; requests are taken only between queries.
`default_nettype none
`include "assert_macros.svh"

module graph_reachability_dfs_core #(
  parameter int unsigned MAX_VERTICES = grdfs_pkg::MaxVerticesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] opcode, [6:2] node_a, [11:7] node_b, [15:12] zero
  input  logic [grdfs_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [4:0] visited_vertex, [7:5] zero
  output logic [grdfs_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,
  // [0] bad_vertex
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [grdfs_pkg::CountW-1:0]    cfg_data_i
);
  import grdfs_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    walk_busy, emit_any;

  assign cfg_ready_o = 1'b1;
  assign walk_busy   = cmd.push || cmd.pop_req || cmd.finish;
  assign emit_any    = cmd.push || cmd.finish || cmd.emit_bad;

  grdfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  grdfs_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_bad_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `GRDFS_NEVER(a_no_accept_in_walk, s_axis_tready && walk_busy, "request accepted during walk")
  `GRDFS_ASSERT(a_emit_needs_slot, emit_any |-> sts.slot_free, "result overwrote pending output")
  `GRDFS_ASSERT(a_bad_is_last, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "bad without last")
  `GRDFS_ASSERT(a_finish_to_idle, cmd.finish |=> s_axis_tready, "no idle after last result")

endmodule

`default_nettype wire
